/* rtl/core/pgp_pkg.sv */
// ----------------------------------------------------------------------------
// pgp_pkg
// Shared types and constants for the OpenPGP packet stream checker.
// ----------------------------------------------------------------------------
package pgp_pkg;

	// Limits of the checks.
	localparam int          MAX_FIRST_BODY   = 65535;
	localparam int          MAX_STREAM_BYTES = 65536;
	localparam logic [16:0] PKT_LIMIT        = (MAX_STREAM_BYTES < 131071) ?
		17'(MAX_STREAM_BYTES) : 17'h1FFFF;

	// Header decode constants.
	localparam logic [5:0] TAG_PUBLIC_KEY = 6'd6;
	localparam logic [7:0] KEY_VERSION    = 8'd4;

	// Result status codes.
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_NO_MARKER   = 4'd1;
	localparam logic [3:0] ST_PARTIAL     = 4'd2;
	localparam logic [3:0] ST_INDETERM    = 4'd3;
	localparam logic [3:0] ST_TRUNCATED   = 4'd4;
	localparam logic [3:0] ST_NOT_KEY     = 4'd5;
	localparam logic [3:0] ST_BAD_VERSION = 4'd6;
	localparam logic [3:0] ST_TOO_BIG     = 4'd7;
	localparam logic [3:0] ST_SECOND_KEY  = 4'd8;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_HDR,
		PH_NEW_L0,
		PH_NEW_L1,
		PH_LEN,
		PH_BODY,
		PH_DONE
	} pgp_phase_t;

	// One input item as held in the input register.
	typedef struct packed {
		logic       last_byte;
		logic [7:0] data_byte;
	} pgp_item_t;

	// One result item.
	typedef struct packed {
		logic [16:0] packet_count;
		logic [15:0] first_body_length;
		logic [2:0]  first_body_offset;
		logic [3:0]  status;
	} pgp_result_t;

	// Handshake between the parser and the output register.
	typedef struct packed {
		logic emit;
		logic out_free;
	} pgp_out_ctl_t;

	// Parser state.
	typedef struct packed {
		pgp_phase_t  phase;
		logic [7:0]  hdr;
		logic [2:0]  len_left;
		logic [31:0] accum;
		logic [31:0] body_left;
		logic        first;
		logic        ver_pend;
		logic [3:0]  err;
		logic [2:0]  offset;
		logic [15:0] flen;
		logic [16:0] pkts;
	} pgp_state_t;

	localparam pgp_state_t STATE_RESET = '{
		phase:     PH_HDR,
		hdr:       8'd0,
		len_left:  3'd0,
		accum:     32'd0,
		body_left: 32'd0,
		first:     1'b1,
		ver_pend:  1'b0,
		err:       ST_OK,
		offset:    3'd0,
		flen:      16'd0,
		pkts:      17'd0
	};

endpackage

/* rtl/core/pgp_in_stage.sv */
// ----------------------------------------------------------------------------
// pgp_in_stage
// Input register that holds one stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module pgp_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pgp_pkg::pgp_item_t in_item,
	output logic              valid_s1,
	output pgp_pkg::pgp_item_t item_s1,
	input  logic              take
);

	// The register frees up in the same cycle that the parser consumes it.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* rtl/core/pgp_parse_core.sv */
// ----------------------------------------------------------------------------
// pgp_parse_core
// Header decoder and check state, one byte per cycle unless a last byte stalls.
// ----------------------------------------------------------------------------
module pgp_parse_core #(
	parameter int MAX_FIRST_BODY   = pgp_pkg::MAX_FIRST_BODY,
	parameter int MAX_STREAM_BYTES = pgp_pkg::MAX_STREAM_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  pgp_pkg::pgp_item_t   item_s1,
	output logic                 take,
	output pgp_pkg::pgp_out_ctl_t ctl,
	input  logic                 out_free,
	output pgp_pkg::pgp_result_t result
);

	// Limits at the widths of the state fields they are compared with.
	localparam logic [31:0] FIRST_BODY_LIMIT = 32'(MAX_FIRST_BODY);
	localparam logic [16:0] PKT_LIMIT        = (MAX_STREAM_BYTES < 131071) ?
		17'(MAX_STREAM_BYTES) : 17'h1FFFF;

	pgp_pkg::pgp_state_t cur_q;
	pgp_pkg::pgp_state_t nxt;
	logic [7:0]          b;
	logic [5:0]          tag;
	logic                key;
	logic                hd;
	logic [31:0]         hd_len;
	logic [2:0]          left_dec;
	logic [31:0]         body_dec;

	assign b = item_s1.data_byte;

	// A last byte waits until the output register can take its result.
	assign take         = valid_s1 && (!item_s1.last_byte || out_free);
	assign ctl.emit     = take && item_s1.last_byte;
	assign ctl.out_free = out_free;

	// Tag of the packet whose header byte is held.
	assign tag = cur_q.hdr[6] ? cur_q.hdr[5:0] : {2'b00, cur_q.hdr[5:2]};
	assign key = (tag == pgp_pkg::TAG_PUBLIC_KEY);

	assign left_dec = cur_q.len_left - 3'd1;
	assign body_dec = cur_q.body_left - 32'd1;

	// Next state for one byte.
	always_comb begin
		nxt    = cur_q;
		hd     = 1'b0;
		hd_len = 32'd0;
		case (cur_q.phase)
			pgp_pkg::PH_HDR: begin
				nxt.hdr = b;
				if (!b[7]) begin
					nxt.err   = pgp_pkg::ST_NO_MARKER;
					nxt.phase = pgp_pkg::PH_DONE;
				end else if (b[6]) begin
					nxt.phase = pgp_pkg::PH_NEW_L0;
				end else if (b[1:0] == 2'd3) begin
					nxt.err   = pgp_pkg::ST_INDETERM;
					nxt.phase = pgp_pkg::PH_DONE;
				end else begin
					nxt.len_left = (b[1:0] == 2'd0) ? 3'd1 :
						(b[1:0] == 2'd1) ? 3'd2 : 3'd4;
					if (cur_q.first) begin
						nxt.offset = 3'd1 + nxt.len_left;
					end
					nxt.accum = 32'd0;
					nxt.phase = pgp_pkg::PH_LEN;
				end
			end
			pgp_pkg::PH_NEW_L0: begin
				if (b < 8'd192) begin
					if (cur_q.first) begin
						nxt.offset = 3'd2;
					end
					hd     = 1'b1;
					hd_len = {24'd0, b};
				end else if (b < 8'd224) begin
					if (cur_q.first) begin
						nxt.offset = 3'd3;
					end
					nxt.accum = {24'd0, b - 8'd192};
					nxt.phase = pgp_pkg::PH_NEW_L1;
				end else if (b == 8'd255) begin
					if (cur_q.first) begin
						nxt.offset = 3'd6;
					end
					nxt.accum    = 32'd0;
					nxt.len_left = 3'd4;
					nxt.phase    = pgp_pkg::PH_LEN;
				end else begin
					nxt.err   = pgp_pkg::ST_PARTIAL;
					nxt.phase = pgp_pkg::PH_DONE;
				end
			end
			pgp_pkg::PH_NEW_L1: begin
				hd     = 1'b1;
				hd_len = {cur_q.accum[23:0], 8'd0} + {24'd0, b} + 32'd192;
			end
			pgp_pkg::PH_LEN: begin
				nxt.accum    = {cur_q.accum[23:0], b};
				nxt.len_left = left_dec;
				if (left_dec == 3'd0) begin
					hd     = 1'b1;
					hd_len = {cur_q.accum[23:0], b};
				end
			end
			pgp_pkg::PH_BODY: begin
				if (cur_q.ver_pend) begin
					nxt.ver_pend = 1'b0;
					if (!key) begin
						nxt.err = pgp_pkg::ST_NOT_KEY;
					end else if (b != pgp_pkg::KEY_VERSION) begin
						nxt.err = pgp_pkg::ST_BAD_VERSION;
					end else if (cur_q.accum > FIRST_BODY_LIMIT) begin
						nxt.err = pgp_pkg::ST_TOO_BIG;
					end else begin
						nxt.err = pgp_pkg::ST_OK;
					end
				end
				nxt.body_left = body_dec;
				if (body_dec == 32'd0) begin
					nxt.first = 1'b0;
					nxt.phase = (nxt.err != pgp_pkg::ST_OK) ?
						pgp_pkg::PH_DONE : pgp_pkg::PH_HDR;
				end
			end
			default: begin
			end
		endcase

		// A header whose length is complete.
		if (hd) begin
			nxt.accum = hd_len;
			if (cur_q.pkts < PKT_LIMIT) begin
				nxt.pkts = cur_q.pkts + 17'd1;
			end
			if (cur_q.first) begin
				nxt.flen = (hd_len > 32'h0000FFFF) ? 16'hFFFF : hd_len[15:0];
				if (hd_len == 32'd0) begin
					nxt.err   = key ? pgp_pkg::ST_BAD_VERSION : pgp_pkg::ST_NOT_KEY;
					nxt.phase = pgp_pkg::PH_DONE;
				end else begin
					nxt.ver_pend  = 1'b1;
					nxt.err       = pgp_pkg::ST_OK;
					nxt.body_left = hd_len;
					nxt.phase     = pgp_pkg::PH_BODY;
				end
			end else if (hd_len == 32'd0) begin
				if (key) begin
					nxt.err   = pgp_pkg::ST_SECOND_KEY;
					nxt.phase = pgp_pkg::PH_DONE;
				end else begin
					nxt.phase = pgp_pkg::PH_HDR;
				end
			end else begin
				nxt.err       = key ? pgp_pkg::ST_SECOND_KEY : pgp_pkg::ST_OK;
				nxt.body_left = hd_len;
				nxt.phase     = pgp_pkg::PH_BODY;
			end
		end
	end

	// Result fields taken from the state after the last byte.
	always_comb begin
		case (nxt.phase)
			pgp_pkg::PH_DONE: result.status = nxt.err;
			pgp_pkg::PH_HDR:  result.status = pgp_pkg::ST_OK;
			default:          result.status = pgp_pkg::ST_TRUNCATED;
		endcase
		result.first_body_offset = nxt.offset;
		result.first_body_length = nxt.flen;
		result.packet_count      = nxt.pkts;
	end

	// State register; the last byte of a stream returns it to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= pgp_pkg::STATE_RESET;
		end else if (take) begin
			cur_q <= item_s1.last_byte ? pgp_pkg::STATE_RESET : nxt;
		end
	end

`ifndef NO_ASSERTIONS
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> (cur_q.phase == pgp_pkg::PH_HDR && cur_q.pkts == 17'd0 && cur_q.first))
		else $error("parser state not cleared after the last byte");
	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q.phase == pgp_pkg::PH_BODY) |-> (cur_q.body_left != 32'd0))
		else $error("body phase with no bytes left");
	a_version_in_first: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q.ver_pend |-> (cur_q.phase == pgp_pkg::PH_BODY && cur_q.first))
		else $error("version check pending outside the first body");
	a_done_has_error: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q.phase == pgp_pkg::PH_DONE) |-> (cur_q.err != pgp_pkg::ST_OK))
		else $error("done phase without an error code");
`endif

endmodule

/* rtl/core/pgp_out_stage.sv */
// ----------------------------------------------------------------------------
// pgp_out_stage
// Result register that holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module pgp_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pgp_pkg::pgp_out_ctl_t ctl,
	output logic                  out_free,
	input  pgp_pkg::pgp_result_t  result,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pgp_pkg::pgp_result_t  out_result
);

	logic                 valid_q;
	pgp_pkg::pgp_result_t result_q;

	// The slot is free when empty or emptied by a transfer this cycle.
	assign out_free   = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.out_free) begin
			valid_q <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			result_q <= result;
		end
	end

endmodule

/* rtl/core/pgp_packet_stream_checker_unit.sv */
// ----------------------------------------------------------------------------
// pgp_packet_stream_checker_unit
// Checks the packet framing of a binary OpenPGP key stream.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one stream byte per transfer in s_axis_tdata, with
// s_axis_tlast on the final byte. Header bytes are decoded, bodies are skipped,
// and the first packet is checked as a version-4 public key.
// The master stream carries one result per stream, sent for the byte marked
// tlast: status, offset and length of the first body, and the packet count.
// Bytes without tlast produce no transfer on the master side.
// Throughput is one byte per cycle, except that a last byte waits while the
// output register is full: every byte is decoded combinationally between the
// input register and parser state register. A last byte's result is written
// to the output register, which drives m_axis_tvalid.
// When the receiver stalls, the result waits in the output register and bytes
// keep flowing; only a further last byte waits in the input register until
// the pending result is taken.
// Reset clears the parser to the start of a stream and empties both registers.
// ----------------------------------------------------------------------------
module pgp_packet_stream_checker_unit #(
	parameter int MAX_FIRST_BODY   = pgp_pkg::MAX_FIRST_BODY,
	parameter int MAX_STREAM_BYTES = pgp_pkg::MAX_STREAM_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tlast,  // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [3:0] status, [6:4] first_body_offset, [22:7] first_body_length,
	// [39:23] packet_count
	output logic [39:0] m_axis_tdata
);

	pgp_pkg::pgp_item_t    in_item;
	pgp_pkg::pgp_item_t    item_s1;
	logic                  valid_s1;
	logic                  take;
	logic                  out_free;
	pgp_pkg::pgp_out_ctl_t ctl;
	pgp_pkg::pgp_result_t  result;
	pgp_pkg::pgp_result_t  out_result;

	assign in_item.data_byte = s_axis_tdata;
	assign in_item.last_byte = s_axis_tlast;

	// Input register.
	pgp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take)
	);

	// Header decoder and checks.
	pgp_parse_core #(
		.MAX_FIRST_BODY   (MAX_FIRST_BODY),
		.MAX_STREAM_BYTES (MAX_STREAM_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take),
		.ctl      (ctl),
		.out_free (out_free),
		.result   (result)
	);

	// Result register.
	pgp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.out_free   (out_free),
		.result     (result),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (out_result)
	);

	assign m_axis_tdata = out_result;

endmodule
